### sv/ilt_pkg.sv
// ---------------------------------------------------------------------------
// ilt_pkg: shared types and constants of the line tracker PID block
// Stream layouts, configuration record, sensor pattern classifier and the
// control record handed from the sequencer to the PID multiply unit.
// ---------------------------------------------------------------------------
package ilt_pkg;

    // stream widths
    localparam int IN_W       = 56;
    localparam int OUT_W      = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // parameter defaults
    localparam int ALL_ONES_LIMIT_DEF = 3;
    localparam int SUM_LIMIT_DEF      = 25600;
    localparam int BEEP_MS_DEF        = 100;
    localparam int REARM_MS_DEF       = 500;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_TURN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLIGHT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEDIUM     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXTREME    = 3'd7;

    // sensor pattern kinds
    localparam logic [2:0] K_NONE      = 3'd0;
    localparam logic [2:0] K_WEIGHT    = 3'd1;
    localparam logic [2:0] K_CENTER    = 3'd2;
    localparam logic [2:0] K_ALL_ONES  = 3'd3;
    localparam logic [2:0] K_LEFT_OUT  = 3'd4;
    localparam logic [2:0] K_RIGHT_OUT = 3'd5;

    // weight selects
    localparam logic [1:0] W_SLIGHT  = 2'd0;
    localparam logic [1:0] W_MEDIUM  = 2'd1;
    localparam logic [1:0] W_STRONG  = 2'd2;
    localparam logic [1:0] W_EXTREME = 2'd3;

    // 0.2 in Q.8
    localparam logic [12:0] FRAC_STEP = 13'd51;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] wsel;
        logic       neg;
        logic       frac;
        logic       mark_l;
        logic       mark_r;
    } cls_t;

    typedef struct packed {
        cls_t               cls;
        logic               read_ok;
        logic signed [11:0] heading;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [9:0]  full_turn_drive;
        logic [11:0] slight_weight;
        logic [11:0] medium_weight;
        logic [11:0] strong_weight;
        logic [11:0] extreme_weight;
    } cfg_t;

    typedef struct packed {
        logic signed [13:0] e;
        logic signed [23:0] sum;
        logic signed [14:0] diff;
    } pid_op_t;

    typedef struct packed {
        logic    start;
        pid_op_t op;
    } pid_req_t;

    // priority table of sensor patterns
    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        c        = '0;
        c.kind   = K_NONE;
        c.mark_l = ((b & 8'hC1) == 8'h01);
        c.mark_r = ((b & 8'h83) == 8'h80);
        unique case (b)
            8'hEF: begin c.kind = K_WEIGHT; c.wsel = W_SLIGHT; end
            8'hF7: begin c.kind = K_WEIGHT; c.wsel = W_SLIGHT; c.neg = 1'b1; end
            8'hCF: begin c.kind = K_WEIGHT; c.wsel = W_SLIGHT; c.frac = 1'b1; end
            8'hF3: begin c.kind = K_WEIGHT; c.wsel = W_SLIGHT; c.frac = 1'b1; c.neg = 1'b1; end
            8'hDF: begin c.kind = K_WEIGHT; c.wsel = W_MEDIUM; end
            8'hFB: begin c.kind = K_WEIGHT; c.wsel = W_MEDIUM; c.neg = 1'b1; end
            8'h9F: begin c.kind = K_WEIGHT; c.wsel = W_MEDIUM; c.frac = 1'b1; end
            8'hF9: begin c.kind = K_WEIGHT; c.wsel = W_MEDIUM; c.frac = 1'b1; c.neg = 1'b1; end
            8'hBF: begin c.kind = K_WEIGHT; c.wsel = W_STRONG; end
            8'hFD: begin c.kind = K_WEIGHT; c.wsel = W_STRONG; c.neg = 1'b1; end
            8'h3F: begin c.kind = K_WEIGHT; c.wsel = W_STRONG; c.frac = 1'b1; end
            8'hFC: begin c.kind = K_WEIGHT; c.wsel = W_STRONG; c.frac = 1'b1; c.neg = 1'b1; end
            8'h7F: begin c.kind = K_WEIGHT; c.wsel = W_EXTREME; end
            8'hFE: begin c.kind = K_WEIGHT; c.wsel = W_EXTREME; c.neg = 1'b1; end
            8'hE7: c.kind = K_CENTER;
            8'hFF: c.kind = K_ALL_ONES;
            default:
            begin
                if (((b & 8'h07) == 8'h07) || ((b & 8'h57) == 8'h03) ||
                    ((b & 8'h2B) == 8'h01))
                begin
                    c.kind = K_LEFT_OUT;
                end
                else if (((b & 8'hE0) == 8'hE0) || ((b & 8'hEA) == 8'hC0) ||
                         ((b & 8'hD4) == 8'h80))
                begin
                    c.kind = K_RIGHT_OUT;
                end
            end
        endcase
        return c;
    endfunction

endpackage

### sv/ilt_front.sv
// ---------------------------------------------------------------------------
// ilt_front: input side of the line tracker
// Takes transactions from the input stream, classifies the sensor byte and
// pushes the classified item into the work queue.
// ---------------------------------------------------------------------------
module ilt_front
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [ilt_pkg::IN_W-1:0] s_tdata,
    input  logic                  q_full,
    output logic                  q_push,
    output ilt_pkg::item_t        q_item
);
    import ilt_pkg::*;

    // accept whenever the queue has room
    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    // unpack and classify
    always_comb
    begin
        q_item.cls     = classify(s_tdata[7:0]);
        q_item.read_ok = s_tdata[8];
        q_item.heading = s_tdata[20:9];
        q_item.now_ms  = s_tdata[52:21];
    end

endmodule

### sv/ilt_fifo.sv
// ---------------------------------------------------------------------------
// ilt_fifo: short work queue between front and back
// Register based first-in first-out queue of classified items.
// ---------------------------------------------------------------------------
module ilt_fifo
#(
    parameter int DEPTH = ilt_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ilt_pkg::item_t din,
    output logic           full,
    input  logic           pop,
    output ilt_pkg::item_t dout,
    output logic           empty
);
    import ilt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == DEPTH_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

### sv/ilt_pid.sv
// ---------------------------------------------------------------------------
// ilt_pid: shared multiply-accumulate unit for the PID output
// One gain product per cycle, summed at Q.16, floored to Q.8 and saturated
// to signed 32 bits.
// ---------------------------------------------------------------------------
module ilt_pid
(
    input  logic              clk,
    input  logic              rst_n,
    input  ilt_pkg::pid_req_t req,
    input  ilt_pkg::cfg_t     cfg,
    output logic              done,
    output logic signed [31:0] result
);
    import ilt_pkg::*;

    localparam logic [2:0] PH_P    = 3'd0;
    localparam logic [2:0] PH_I    = 3'd1;
    localparam logic [2:0] PH_D    = 3'd2;
    localparam logic [2:0] PH_LAST = 3'd3;
    localparam logic [2:0] PH_FMT  = 3'd4;

    logic               busy_reg;
    logic [2:0]         phase_reg;
    logic [15:0]        gain;
    logic signed [23:0] opnd;
    logic signed [40:0] prod;
    logic signed [40:0] prod_reg;
    logic signed [42:0] acc_reg;
    logic signed [34:0] q;
    logic signed [31:0] sat_val;
    logic               done_reg;
    logic signed [31:0] result_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        case (phase_reg)
            PH_P:    begin gain = cfg.gain_p; opnd = 24'(req.op.e); end
            PH_I:    begin gain = cfg.gain_i; opnd = req.op.sum; end
            PH_D:    begin gain = cfg.gain_d; opnd = 24'(req.op.diff); end
            default: begin gain = '0; opnd = '0; end
        endcase
        prod = 41'($signed({1'b0, gain})) * 41'(opnd);
    end

    // floor to Q.8 and saturate
    always_comb
    begin
        q = acc_reg[42:8];
        if (q > 35'sh0_7FFF_FFFF)
        begin
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (q < -35'sh0_8000_0000)
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = q[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= PH_P;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_P;
            end
            else if (busy_reg)
            begin
                if (phase_reg == PH_FMT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + 3'd1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            prod_reg <= prod;
            if (phase_reg == PH_P)
            begin
                acc_reg <= '0;
            end
            else if ((phase_reg == PH_I) || (phase_reg == PH_D) || (phase_reg == PH_LAST))
            begin
                acc_reg <= acc_reg + 43'(prod_reg);
            end
            if (phase_reg == PH_FMT)
            begin
                result_reg <= sat_val;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

### sv/ilt_back.sv
// ---------------------------------------------------------------------------
// ilt_back: tracker state and result sequencer
// Pops classified items, updates heading, turn, debounce and PID state,
// runs the PID unit when needed and drives the output register.
// ---------------------------------------------------------------------------
module ilt_back
#(
    parameter int ALL_ONES_LIMIT = ilt_pkg::ALL_ONES_LIMIT_DEF,
    parameter int SUM_LIMIT      = ilt_pkg::SUM_LIMIT_DEF,
    parameter int BEEP_MS        = ilt_pkg::BEEP_MS_DEF,
    parameter int REARM_MS       = ilt_pkg::REARM_MS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ilt_pkg::item_t           item,
    input  logic                     q_empty,
    output logic                     q_pop,
    input  ilt_pkg::cfg_t            cfg,
    output ilt_pkg::pid_req_t        pid_req,
    input  logic                     pid_done,
    input  logic signed [31:0]       pid_result,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ilt_pkg::OUT_W-1:0] m_tdata
);
    import ilt_pkg::*;

    localparam logic [7:0]         RUN_LIMIT = 8'(ALL_ONES_LIMIT);
    localparam logic signed [24:0] SUM_MAX   = 25'(SUM_LIMIT);
    localparam logic signed [24:0] SUM_MIN   = -SUM_MAX;
    localparam logic [31:0]        BEEP_LIM  = 32'(BEEP_MS);
    localparam logic [31:0]        REARM_LIM = 32'(REARM_MS);

    localparam logic signed [13:0] GYRO_TURN = 14'sd800;
    localparam logic signed [13:0] HALF_TURN = 14'sd1800;
    localparam logic signed [13:0] FULL_TURN = 14'sd3600;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;

    localparam logic [1:0] MODE_ZERO  = 2'd0;
    localparam logic [1:0] MODE_PID   = 2'd1;
    localparam logic [1:0] MODE_LEFT  = 2'd2;
    localparam logic [1:0] MODE_RIGHT = 2'd3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // sequencer and item
    logic [2:0]  state_reg, state_next;
    item_t       item_reg;

    // prepared values
    logic               prep_beep_exp_reg, prep_rearm_reg;
    logic               prep_gyro_hit_reg, prep_gyro_right_reg;
    logic signed [13:0] prep_e_reg;
    logic signed [13:0] prep_e;
    logic               prep_beep_exp, prep_rearm, prep_gyro_hit, prep_gyro_right;
    logic signed [13:0] hd14, ref14, d0, d1, d2;
    logic [31:0]        elapsed;
    logic [11:0]        w12;
    logic [12:0]        w13;

    // tracker state
    logic signed [11:0] ref_reg, ref_next;
    logic signed [13:0] cur_reg, cur_next;
    logic signed [13:0] prev_reg, prev_next;
    logic signed [13:0] held_reg, held_next;
    logic signed [23:0] sum_reg, sum_next;
    logic               hold_reg, hold_next;
    logic [7:0]         run_reg, run_next;
    logic               lo_reg, lo_next;
    logic               ro_reg, ro_next;
    logic [1:0]         dir_reg, dir_next;
    logic               allow_reg, allow_next;
    logic [31:0]        last_reg, last_next;
    logic               beep_reg, beep_next;
    logic [15:0]        lc_reg, lc_next;
    logic [15:0]        rc_reg, rc_next;
    logic [15:0]        glc_reg, glc_next;
    logic [15:0]        grc_reg, grc_next;

    // evaluation temporaries
    logic               is_ff, allow1, allow2, cnt_l, cnt_r;
    logic [15:0]        g_inc;
    logic signed [24:0] sum_wide;
    logic [1:0]         mode_next;
    pid_op_t            op_reg, op_next;
    logic signed [31:0] hard32;
    logic signed [31:0] drive_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               out_load;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: state_next = S_EVAL;
            S_EVAL: state_next = (mode_next == MODE_PID) ? S_MUL : S_OUT;
            S_MUL:
            begin
                if (pid_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // heading difference, timers and line error
    always_comb
    begin
        hd14  = 14'(item_reg.heading);
        ref14 = 14'(ref_reg);
        d0    = ref14 - hd14;
        d1    = (d0 <= -HALF_TURN) ? d0 + FULL_TURN : d0;
        d2    = (d1 >= HALF_TURN) ? d1 - FULL_TURN : d1;
        prep_gyro_hit   = (d2 >= GYRO_TURN) || (d2 <= -GYRO_TURN);
        prep_gyro_right = (d2 > 14'sd0);

        elapsed       = item_reg.now_ms - last_reg;
        prep_beep_exp = (elapsed > BEEP_LIM);
        prep_rearm    = (elapsed > REARM_LIM);

        unique case (item_reg.cls.wsel)
            W_SLIGHT:  w12 = cfg.slight_weight;
            W_MEDIUM:  w12 = cfg.medium_weight;
            W_STRONG:  w12 = cfg.strong_weight;
            W_EXTREME: w12 = cfg.extreme_weight;
            default:   w12 = cfg.slight_weight;
        endcase
        w13 = {1'b0, w12} + (item_reg.cls.frac ? FRAC_STEP : 13'd0);
        if (item_reg.cls.kind != K_WEIGHT)
        begin
            prep_e = '0;
        end
        else if (item_reg.cls.neg)
        begin
            prep_e = -$signed({1'b0, w13});
        end
        else
        begin
            prep_e = $signed({1'b0, w13});
        end
    end

    assign hard32 = $signed(32'({cfg.full_turn_drive, 8'h00}));

    // one control tick
    always_comb
    begin
        ref_next   = ref_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        held_next  = held_reg;
        sum_next   = sum_reg;
        hold_next  = hold_reg;
        run_next   = run_reg;
        lo_next    = lo_reg;
        ro_next    = ro_reg;
        dir_next   = dir_reg;
        allow_next = allow_reg;
        last_next  = last_reg;
        beep_next  = beep_reg;
        lc_next    = lc_reg;
        rc_next    = rc_reg;
        glc_next   = glc_reg;
        grc_next   = grc_reg;
        mode_next  = MODE_ZERO;
        op_next    = op_reg;
        is_ff      = (item_reg.cls.kind == K_ALL_ONES);
        allow1     = prep_rearm_reg | allow_reg;
        allow2     = allow1;
        cnt_l      = 1'b0;
        cnt_r      = 1'b0;
        g_inc      = '0;
        sum_wide   = '0;

        if (!item_reg.read_ok)
        begin
            // failed read: no state change; steer on the held error while holding, else zero drive
            if (hold_reg)
            begin
                mode_next   = MODE_PID;
                op_next.e   = held_reg;
                op_next.sum = sum_reg;
                op_next.diff = 15'(held_reg) - 15'(prev_reg);
            end
        end
        else
        begin
            beep_next = prep_beep_exp_reg ? 1'b0 : beep_reg;
            run_next  = is_ff ? ((run_reg == 8'hFF) ? run_reg : run_reg + 8'd1) : 8'd0;
            hold_next = is_ff && (run_next < RUN_LIMIT);
            held_next = is_ff ? held_reg : cur_reg;

            if (hold_next)
            begin
                // short all-ones run: keep steering on the held error
                mode_next    = MODE_PID;
                op_next.e    = held_next;
                op_next.sum  = sum_reg;
                op_next.diff = 15'(held_next) - 15'(prev_reg);
                prev_next    = held_next;
            end
            else if (is_ff && (lo_reg || ro_reg))
            begin
                // line lost after leaving on one side: hard turn
                if ((dir_reg == DIR_NONE) && allow1)
                begin
                    if (ro_reg)
                    begin
                        dir_next = DIR_RIGHT;
                        cnt_r    = 1'b1;
                    end
                    else
                    begin
                        dir_next = DIR_LEFT;
                        cnt_l    = 1'b1;
                    end
                end
                mode_next = lo_reg ? MODE_LEFT : MODE_RIGHT;
            end
            else
            begin
                // gyro turn correction
                if (prep_gyro_hit_reg)
                begin
                    ref_next = item_reg.heading;
                    if (prep_gyro_right_reg)
                    begin
                        g_inc    = sat_inc16(grc_reg);
                        grc_next = g_inc;
                        cnt_r    = (g_inc > rc_reg);
                    end
                    else
                    begin
                        g_inc    = sat_inc16(glc_reg);
                        glc_next = g_inc;
                        cnt_l    = (g_inc > lc_reg);
                    end
                end
                allow2 = allow1 & ~(cnt_l | cnt_r);

                case (item_reg.cls.kind) inside
                    K_LEFT_OUT, K_ALL_ONES:
                    begin
                        if (!lo_reg && !ro_reg)
                        begin
                            lo_next = 1'b1;
                        end
                        dir_next = DIR_NONE;
                        if (allow2)
                        begin
                            cnt_l = 1'b1;
                        end
                        mode_next = MODE_LEFT;
                    end
                    K_RIGHT_OUT:
                    begin
                        if (!lo_reg && !ro_reg)
                        begin
                            ro_next = 1'b1;
                        end
                        dir_next = DIR_NONE;
                        if (allow2)
                        begin
                            cnt_r = 1'b1;
                        end
                        mode_next = MODE_RIGHT;
                    end
                    default:
                    begin
                        if (item_reg.cls.kind == K_CENTER)
                        begin
                            ref_next = item_reg.heading;
                        end
                        cur_next = prep_e_reg;
                        if (item_reg.cls.mark_l || item_reg.cls.mark_r)
                        begin
                            if (!lo_reg && !ro_reg)
                            begin
                                lo_next = item_reg.cls.mark_l;
                                ro_next = ~item_reg.cls.mark_l;
                            end
                            dir_next = DIR_NONE;
                        end
                        // clamped integral
                        sum_wide = 25'(sum_reg) + 25'(prep_e_reg);
                        if (sum_wide > SUM_MAX)
                        begin
                            sum_wide = SUM_MAX;
                        end
                        else if (sum_wide < SUM_MIN)
                        begin
                            sum_wide = SUM_MIN;
                        end
                        sum_next     = sum_wide[23:0];
                        mode_next    = MODE_PID;
                        op_next.e    = prep_e_reg;
                        op_next.sum  = sum_wide[23:0];
                        op_next.diff = 15'(prep_e_reg) - 15'(prev_reg);
                        prev_next    = prep_e_reg;
                    end
                endcase
            end

            // counted turn
            allow_next = allow1;
            if (cnt_l)
            begin
                lc_next = sat_inc16(lc_reg);
            end
            if (cnt_r)
            begin
                rc_next = sat_inc16(rc_reg);
            end
            if (cnt_l || cnt_r)
            begin
                last_next  = item_reg.now_ms;
                beep_next  = 1'b1;
                allow_next = 1'b0;
            end
        end
    end

    assign pid_req.start = (state_reg == S_EVAL) && (mode_next == MODE_PID);
    assign pid_req.op    = op_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ref_reg      <= '0;
            cur_reg      <= '0;
            prev_reg     <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
            hold_reg     <= 1'b0;
            run_reg      <= '0;
            lo_reg       <= 1'b0;
            ro_reg       <= 1'b0;
            dir_reg      <= DIR_NONE;
            allow_reg    <= 1'b0;
            last_reg     <= '0;
            beep_reg     <= 1'b0;
            lc_reg       <= '0;
            rc_reg       <= '0;
            glc_reg      <= '0;
            grc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EVAL)
            begin
                ref_reg   <= ref_next;
                cur_reg   <= cur_next;
                prev_reg  <= prev_next;
                held_reg  <= held_next;
                sum_reg   <= sum_next;
                hold_reg  <= hold_next;
                run_reg   <= run_next;
                lo_reg    <= lo_next;
                ro_reg    <= ro_next;
                dir_reg   <= dir_next;
                allow_reg <= allow_next;
                last_reg  <= last_next;
                beep_reg  <= beep_next;
                lc_reg    <= lc_next;
                rc_reg    <= rc_next;
                glc_reg   <= glc_next;
                grc_reg   <= grc_next;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= item;
        end
        if (state_reg == S_PREP)
        begin
            prep_beep_exp_reg   <= prep_beep_exp;
            prep_rearm_reg      <= prep_rearm;
            prep_gyro_hit_reg   <= prep_gyro_hit;
            prep_gyro_right_reg <= prep_gyro_right;
            prep_e_reg          <= prep_e;
        end
        if (state_reg == S_EVAL)
        begin
            op_reg <= op_next;
            unique case (mode_next)
                MODE_LEFT:  drive_reg <= hard32;
                MODE_RIGHT: drive_reg <= -hard32;
                MODE_ZERO:  drive_reg <= '0;
                MODE_PID:   drive_reg <= '0;
                default:    drive_reg <= '0;
            endcase
        end
        if ((state_reg == S_MUL) && pid_done)
        begin
            drive_reg <= pid_result;
        end
        if (out_load)
        begin
            m_tdata_reg <= {7'b0, rc_reg, lc_reg, beep_reg, drive_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### sv/ir_line_tracker_pid_top.sv
// ---------------------------------------------------------------------------
// ir_line_tracker_pid_top: infrared line tracker with PID steering
// One input transaction is one control tick; one output transaction is the
// steering drive, beeper state and turn counts after that tick.
// ---------------------------------------------------------------------------
// Usage:
//   s_* stream: one control tick per transaction. tdata fields from bit 0:
//     sensor_byte[7:0], read_ok[8], heading[20:9], now_ms[52:21], zero pad.
//   m_* stream: one result per tick, in order. tdata fields from bit 0:
//     drive[31:0], beep[32], left_turns[48:33], right_turns[64:49], zero pad.
//   cfg_*: register writes, taken on any edge with cfg_we high; write only
//     while no tick is in flight.
// Flow: a tick passes the sequencer states IDLE, PREP, EVAL and OUT; one that
//   runs the PID also waits in MUL for the five-step shared multiply-accumulate
//   unit, while hard turn and zero-drive ticks skip MUL. The back end handles
//   one tick at a time and pops the next once the current result is loaded.
// A four-entry queue keeps s_tready high while earlier ticks are processed;
//   the output register holds a result while m_tready is low, and once the
//   queue fills s_tready drops.
// Reset clears all tracker state, counters and the queue, and loads the
//   register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module ir_line_tracker_pid_top
#(
    parameter int ALL_ONES_LIMIT = ilt_pkg::ALL_ONES_LIMIT_DEF,
    parameter int SUM_LIMIT      = ilt_pkg::SUM_LIMIT_DEF,
    parameter int BEEP_MS        = ilt_pkg::BEEP_MS_DEF,
    parameter int REARM_MS       = ilt_pkg::REARM_MS_DEF,
    parameter int QUEUE_DEPTH    = ilt_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sensor_byte, read_ok, heading, now_ms, zero pad
    input  logic [ilt_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // drive, beep, left_turns, right_turns, zero pad
    output logic [ilt_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_we,
    input  logic [ilt_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ilt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import ilt_pkg::*;

    cfg_t               cfg_reg;
    item_t              push_item, head_item;
    logic               q_push, q_full, q_pop, q_empty;
    pid_req_t           pid_req;
    logic               pid_done;
    logic signed [31:0] pid_result;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= 16'd0;
            cfg_reg.gain_i          <= 16'd0;
            cfg_reg.gain_d          <= 16'd0;
            cfg_reg.full_turn_drive <= 10'd150;
            cfg_reg.slight_weight   <= 12'd256;
            cfg_reg.medium_weight   <= 12'd512;
            cfg_reg.strong_weight   <= 12'd1024;
            cfg_reg.extreme_weight  <= 12'd1536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_P:    cfg_reg.gain_p          <= cfg_wdata;
                REG_GAIN_I:    cfg_reg.gain_i          <= cfg_wdata;
                REG_GAIN_D:    cfg_reg.gain_d          <= cfg_wdata;
                REG_FULL_TURN: cfg_reg.full_turn_drive <= cfg_wdata[9:0];
                REG_SLIGHT:    cfg_reg.slight_weight   <= cfg_wdata[11:0];
                REG_MEDIUM:    cfg_reg.medium_weight   <= cfg_wdata[11:0];
                REG_STRONG:    cfg_reg.strong_weight   <= cfg_wdata[11:0];
                REG_EXTREME:   cfg_reg.extreme_weight  <= cfg_wdata[11:0];
                default:       cfg_reg.gain_p          <= cfg_reg.gain_p;
            endcase
        end
    end

    ilt_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    ilt_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (push_item),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (head_item),
        .empty (q_empty)
    );

    ilt_back
    #(
        .ALL_ONES_LIMIT (ALL_ONES_LIMIT),
        .SUM_LIMIT      (SUM_LIMIT),
        .BEEP_MS        (BEEP_MS),
        .REARM_MS       (REARM_MS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (head_item),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .cfg        (cfg_reg),
        .pid_req    (pid_req),
        .pid_done   (pid_done),
        .pid_result (pid_result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    ilt_pid u_pid
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (pid_req),
        .cfg    (cfg_reg),
        .done   (pid_done),
        .result (pid_result)
    );

endmodule

### sv/ilt_checker.sv
// ---------------------------------------------------------------------------
// ilt_checker: port level checks of the line tracker
// Watches the output stream: held results, monotonic turn counts and the
// beeper following a counted turn.
// ---------------------------------------------------------------------------
module ilt_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ilt_pkg::OUT_W-1:0] m_tdata
);
    import ilt_pkg::*;

    logic [15:0] last_left_reg;
    logic [15:0] last_right_reg;

    // counts seen in the previous output transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            last_left_reg  <= m_tdata[48:33];
            last_right_reg <= m_tdata[64:49];
        end
    end

    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("output valid dropped while stalled");

    // a stalled result keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("output payload changed while stalled");

    // turn counts never go back
    a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |->
        ((m_tdata[48:33] >= last_left_reg) && (m_tdata[64:49] >= last_right_reg)))
        else $error("turn count decreased");

    // a newly counted turn switches the beeper on
    a_beep_on_turn: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready &&
         ((m_tdata[48:33] != last_left_reg) || (m_tdata[64:49] != last_right_reg)))
        |-> m_tdata[32])
        else $error("counted turn without beeper");

endmodule

bind ir_line_tracker_pid_top ilt_checker u_ilt_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
